// ----- sv/sctab_pkg.sv -----
package sctab_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BOUND_W     = ADDR_W + 1;
    localparam int CFG_W       = 9;
    localparam int POS_W       = 8;
    localparam int CODE_W      = 16;
    localparam int GLYPH_W     = 16;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [CODE_W-1:0]  code;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROBE = 3'b010,
        ST_DONE  = 3'b100
    } state_t;

endpackage

// ----- sv/sctab_mem.sv -----
module sctab_mem
    import sctab_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/sorted_code_table_search.sv -----
// Load transaction: written into the table at the accept edge, no result.
// Search transaction: one table probe per cycle through the single registered read port,
// 0 to ADDR_W+1 probes (none on an empty table, 9 at 256 entries);
// result passes through ST_DONE into the output register once that register is free.
// Next input taken once the result has moved into the output register.
// rst_n (async, active low) clears control, entry count and output valid; table is not cleared.
module sorted_code_table_search
    import sctab_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [55:0]      s_tdata,   // entry_position, entry_code, entry_glyph, search_key
    input  logic [0:0]       s_tuser,   // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // glyph_index
    output logic [0:0]       m_tuser,   // found
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata  // entry_count
);

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     count_reg;
    logic [CODE_W-1:0]    key_reg, key_next;
    logic [BOUND_W-1:0]   lo_reg, lo_next;
    logic [BOUND_W-1:0]   hi_reg, hi_next;     // exclusive upper bound
    logic [ADDR_W-1:0]    mid_reg, mid_next;
    logic                 found_reg, found_next;
    logic [GLYPH_W-1:0]   glyph_reg, glyph_next;
    logic                 m_tvalid_reg;
    logic [GLYPH_W-1:0]   m_tdata_reg;
    logic                 m_tuser_reg;

    logic                 s_fire;
    logic                 out_free;
    logic [POS_W-1:0]     in_pos;
    entry_t               in_entry;
    logic [CODE_W-1:0]    in_key;
    logic [BOUND_W-1:0]   n_eff;
    logic                 wr_en;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    entry_t               rd_data;
    logic                 push;

    function automatic logic [ADDR_W-1:0] mid_of(input logic [BOUND_W-1:0] lo,
                                                 input logic [BOUND_W-1:0] hi);
        logic [BOUND_W:0] sum;
        begin
            sum    = {1'b0, lo} + {1'b0, hi} - (BOUND_W+1)'(1);
            mid_of = sum[ADDR_W:1];
        end
    endfunction

    assign in_pos         = s_tdata[POS_W-1:0];
    assign in_entry.code  = s_tdata[POS_W +: CODE_W];
    assign in_entry.glyph = s_tdata[POS_W+CODE_W +: GLYPH_W];
    assign in_key         = s_tdata[POS_W+CODE_W+GLYPH_W +: CODE_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        if (int'(count_reg) > TABLE_DEPTH)
            n_eff = BOUND_W'(TABLE_DEPTH);
        else
            n_eff = BOUND_W'(count_reg);
    end

    assign wr_en = s_fire && (s_tuser[0] == CMD_LOAD) && (int'(in_pos) < TABLE_DEPTH);

    sctab_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(in_pos)),
        .wr_data (in_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Sequencer: one compare per cycle on the probe read last cycle, next address issued same cycle
    always_comb
    begin
        logic [BOUND_W-1:0] lo_t;
        logic [BOUND_W-1:0] hi_t;
        state_next = state_reg;
        key_next   = key_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        found_next = found_reg;
        glyph_next = glyph_reg;
        rd_en      = 1'b0;
        rd_addr    = mid_reg;
        push       = 1'b0;
        lo_t       = lo_reg;
        hi_t       = hi_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_tuser[0] == CMD_SEARCH))
                begin
                    key_next   = in_key;
                    lo_next    = '0;
                    hi_next    = n_eff;
                    found_next = 1'b0;
                    glyph_next = '0;
                    if (n_eff == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = mid_of('0, n_eff);
                        mid_next   = rd_addr;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (rd_data.code == key_reg)
                begin
                    found_next = 1'b1;
                    glyph_next = rd_data.glyph;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (rd_data.code > key_reg)
                        hi_t = BOUND_W'(mid_reg);
                    else
                        lo_t = BOUND_W'(mid_reg) + BOUND_W'(1);
                    lo_next = lo_t;
                    hi_next = hi_t;
                    if (lo_t < hi_t)
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = mid_of(lo_t, hi_t);
                        mid_next = rd_addr;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            if (push)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        found_reg <= found_next;
        glyph_reg <= glyph_next;
        if (push)
        begin
            m_tdata_reg <= glyph_reg;
            m_tuser_reg <= found_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
